/* rtl/core/assert_macros.svh */
// Assertion macros shared by the cursor overlay RTL.
// Each use expands to one labeled concurrent assertion, disabled while the active-low reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic form: explicit clock and active-low reset.
`define CAO_ASSERT_CLK(lbl, clk_sig, rstn_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) prop) \
    else $error(msg);

// Short form for modules whose clock is clk and reset is rst_n.
`define CAO_ASSERT(lbl, prop, msg) `CAO_ASSERT_CLK(lbl, clk, rst_n, prop, msg)

`endif

/* rtl/core/cao_pkg.sv */
// Shared types and constants for the cursor alpha overlay core.
// No dependencies; every module imports it.
`timescale 1ns / 1ps
`default_nettype none

package cao_pkg;

  localparam int MAX_CURSOR_SIDE_DEF = 64;
  localparam int MAX_FRAME_WIDTH_DEF = 4096;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 4;

  // Signed raster-to-cursor offset; covers column/row up to 14 bits minus a 14-bit left/top.
  localparam int DELTA_W = 17;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  localparam logic [7:0]  ALPHA_FULL = 8'd255;
  localparam logic [7:0]  ALPHA_NONE = 8'd0;
  localparam logic [15:0] ROUND_HALF = 16'd127;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CURSOR_LEFT    = 3'd0,
    REG_CURSOR_TOP     = 3'd1,
    REG_CURSOR_WIDTH   = 3'd2,
    REG_CURSOR_HEIGHT  = 3'd3,
    REG_FRAME_WIDTH    = 3'd4,
    REG_OVERLAY_ENABLE = 3'd5
  } cfg_reg_t;

  localparam logic [13:0] CURSOR_LEFT_RST    = 14'd0;
  localparam logic [13:0] CURSOR_TOP_RST     = 14'd0;
  localparam logic [6:0]  CURSOR_WIDTH_RST   = 7'd0;
  localparam logic [6:0]  CURSOR_HEIGHT_RST  = 7'd0;
  localparam logic [12:0] FRAME_WIDTH_RST    = 13'd640;
  localparam logic        OVERLAY_ENABLE_RST = 1'b1;

  typedef struct packed {
    logic [13:0] cursor_left;
    logic [13:0] cursor_top;
    logic [6:0]  cursor_width;
    logic [6:0]  cursor_height;
    logic [12:0] frame_width;
    logic        overlay_enable;
  } cfg_t;

  // One classified request as it travels from front to back.
  typedef struct packed {
    logic        is_load;
    logic        load_ok;
    logic [11:0] index;
    logic [31:0] word;
    logic [7:0]  pix0;
    logic [7:0]  pix1;
    logic [7:0]  pix2;
    logic        last;
    logic        hit;
  } item_t;

endpackage

`default_nettype wire

/* rtl/core/cao_front.sv */
// Front end: accepts requests, tracks raster position and classifies pixels.
// Depends on cao_pkg; feeds cao_queue.
`timescale 1ns / 1ps
`default_nettype none

module cao_front import cao_pkg::*; #(
  parameter int MAX_CURSOR_SIDE = MAX_CURSOR_SIDE_DEF,
  parameter int MAX_FRAME_WIDTH = MAX_FRAME_WIDTH_DEF,
  localparam int SIDE_W = $clog2(MAX_CURSOR_SIDE),
  localparam int CW_W   = $clog2(MAX_CURSOR_SIDE + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cfg_t              cfg,
  input  wire logic [CW_W-1:0]   cw_eff,
  input  wire logic [CW_W-1:0]   ch_eff,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_opcode,
  input  wire logic [11:0]       in_cursor_index,
  input  wire logic [31:0]       in_cursor_word,
  input  wire logic [7:0]        in_pixel_c0,
  input  wire logic [7:0]        in_pixel_c1,
  input  wire logic [7:0]        in_pixel_c2,
  input  wire logic              in_last_of_frame,
  input  wire logic              q_full,
  output logic                   push,
  output item_t                  push_item,
  output logic [SIDE_W-1:0]      push_dx,
  output logic [SIDE_W-1:0]      push_dy
);

  localparam int COL_W       = $clog2(MAX_FRAME_WIDTH);
  localparam int FW_W        = $clog2(MAX_FRAME_WIDTH + 1);
  localparam int STORE_DEPTH = MAX_CURSOR_SIDE * MAX_CURSOR_SIDE;

  logic [COL_W-1:0]   col_r, col_nxt;
  logic [12:0]        row_r, row_nxt;
  logic [FW_W-1:0]    fw_eff;
  logic [DELTA_W-1:0] dx, dy;
  logic               hit;
  logic               is_pixel;

  assign in_stall = q_full;
  assign push     = in_valid && !in_stall;
  assign is_pixel = (in_opcode == OP_PIXEL);

  always_comb begin
    if (cfg.frame_width == 13'd0) begin
      fw_eff = FW_W'(1);
    end else if (32'(cfg.frame_width) > 32'(MAX_FRAME_WIDTH)) begin
      fw_eff = FW_W'(MAX_FRAME_WIDTH);
    end else begin
      fw_eff = FW_W'(cfg.frame_width);
    end
  end

  // Offsets from the cursor origin, two's complement in DELTA_W bits.
  assign dx = DELTA_W'(col_r) - {{(DELTA_W - 14){cfg.cursor_left[13]}}, cfg.cursor_left};
  assign dy = DELTA_W'(row_r) - {{(DELTA_W - 14){cfg.cursor_top[13]}}, cfg.cursor_top};

  assign hit = cfg.overlay_enable && !dx[DELTA_W-1] && !dy[DELTA_W-1] &&
               (dx < DELTA_W'(cw_eff)) && (dy < DELTA_W'(ch_eff));

  always_comb begin
    push_item.is_load = !is_pixel;
    push_item.load_ok = (32'(in_cursor_index) < 32'(STORE_DEPTH));
    push_item.index   = in_cursor_index;
    push_item.word    = in_cursor_word;
    push_item.pix0    = in_pixel_c0;
    push_item.pix1    = in_pixel_c1;
    push_item.pix2    = in_pixel_c2;
    push_item.last    = in_last_of_frame;
    push_item.hit     = hit;
  end

  // Inside the rectangle both offsets are below MAX_CURSOR_SIDE.
  assign push_dx = dx[SIDE_W-1:0];
  assign push_dy = dy[SIDE_W-1:0];

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (push && is_pixel) begin
      if (in_last_of_frame) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if ((FW_W'(col_r) + FW_W'(1)) >= fw_eff) begin
        col_nxt = '0;
        row_nxt = row_r + 13'd1;
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/cao_queue.sv */
// Short request queue between the front and back of the overlay core.
// Depends on cao_pkg for item_t and QUEUE_DEPTH.
`timescale 1ns / 1ps
`default_nettype none

module cao_queue import cao_pkg::*; #(
  parameter int OFS_W = 6
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire item_t            push_item,
  input  wire logic [OFS_W-1:0] push_dx,
  input  wire logic [OFS_W-1:0] push_dy,
  output logic                  full,
  output logic                  head_valid,
  output item_t                 head_item,
  output logic [OFS_W-1:0]      head_dx,
  output logic [OFS_W-1:0]      head_dy,
  input  wire logic             pop
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            item_q [QUEUE_DEPTH];
  logic [OFS_W-1:0] dx_q   [QUEUE_DEPTH];
  logic [OFS_W-1:0] dy_q   [QUEUE_DEPTH];

  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full       = (count_r == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = item_q[rd_ptr_r];
  assign head_dx    = dx_q[rd_ptr_r];
  assign head_dy    = dy_q[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      item_q[wr_ptr_r] <= push_item;
      dx_q[wr_ptr_r]   <= push_dx;
      dy_q[wr_ptr_r]   <= push_dy;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/cao_back.sv */
// Back end: cursor memory, address generation, alpha blend and output register.
// Depends on cao_pkg and assert_macros.svh; drains cao_queue.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module cao_back import cao_pkg::*; #(
  parameter int MAX_CURSOR_SIDE = MAX_CURSOR_SIDE_DEF,
  localparam int SIDE_W = $clog2(MAX_CURSOR_SIDE),
  localparam int CW_W   = $clog2(MAX_CURSOR_SIDE + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [CW_W-1:0]   cw_eff,
  input  wire logic              q_valid,
  input  wire item_t             q_item,
  input  wire logic [SIDE_W-1:0] q_dx,
  input  wire logic [SIDE_W-1:0] q_dy,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [7:0]             out_c0,
  output logic [7:0]             out_c1,
  output logic [7:0]             out_c2,
  output logic                   out_last
);

  localparam int STORE_DEPTH = MAX_CURSOR_SIDE * MAX_CURSOR_SIDE;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int MUL_W       = SIDE_W + CW_W;

  // x / 255 for x below 65280.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = 17'(x) + 17'd1 + 17'(x[15:8]);
    return t[15:8];
  endfunction

  function automatic logic [7:0] mix(input logic hit, input logic a_full, input logic a_zero,
                                     input logic [7:0] p, input logic [7:0] c,
                                     input logic [15:0] prod);
    logic [7:0] r;
    if (!hit || a_zero) begin
      r = p;
    end else if (a_full) begin
      r = c;
    end else begin
      r = c + div255(prod);
    end
    return r;
  endfunction

  logic [31:0] mem [STORE_DEPTH];

  // stage 1: address
  logic              s1_v_r, s1_load_r, s1_load_ok_r, s1_last_r, s1_hit_r;
  logic [ADDR_W-1:0] s1_addr_r, s1_addr_nxt;
  logic [31:0]       s1_word_r;
  logic [7:0]        s1_p0_r, s1_p1_r, s1_p2_r;
  // stage 2: memory read data
  logic              s2_v_r, s2_last_r, s2_hit_r;
  logic [31:0]       rd_r;
  logic [7:0]        s2_p0_r, s2_p1_r, s2_p2_r;
  // stage 3: products
  logic              s3_v_r, s3_last_r, s3_hit_r, s3_full_r, s3_zero_r;
  logic [7:0]        s3_p0_r, s3_p1_r, s3_p2_r, s3_c0_r, s3_c1_r, s3_c2_r;
  logic [15:0]       s3_m0_r, s3_m1_r, s3_m2_r;
  logic [15:0]       m0_nxt, m1_nxt, m2_nxt;
  logic [7:0]        inv_alpha;
  // output register
  logic              out_valid_r, out_last_r;
  logic [7:0]        out_c0_r, out_c1_r, out_c2_r;

  logic              out_rdy, s3_rdy, s2_rdy, s1_rdy, s1_adv;
  logic [MUL_W-1:0]  lin_addr;
  logic [31:0]       idx_ext;

  assign out_rdy = !out_valid_r || !out_stall;
  assign s3_rdy  = !s3_v_r || out_rdy;
  assign s2_rdy  = !s2_v_r || s3_rdy;
  assign s1_rdy  = !s1_v_r || s2_rdy;
  assign s1_adv  = s1_v_r && s2_rdy;
  assign q_pop   = q_valid && s1_rdy;

  assign lin_addr    = MUL_W'(q_dy) * MUL_W'(cw_eff) + MUL_W'(q_dx);
  assign idx_ext     = 32'(q_item.index);
  assign s1_addr_nxt = q_item.is_load ? idx_ext[ADDR_W-1:0] : lin_addr[ADDR_W-1:0];

  assign inv_alpha = ALPHA_FULL - rd_r[31:24];
  assign m0_nxt    = 16'(s2_p0_r) * 16'(inv_alpha) + ROUND_HALF;
  assign m1_nxt    = 16'(s2_p1_r) * 16'(inv_alpha) + ROUND_HALF;
  assign m2_nxt    = 16'(s2_p2_r) * 16'(inv_alpha) + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_r <= q_valid;
      // drop loads here: they end at the memory write
      if (s2_rdy) s2_v_r <= s1_v_r && !s1_load_r;
      if (s3_rdy) s3_v_r <= s2_v_r;
      if (out_rdy) out_valid_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_load_r    <= q_item.is_load;
      s1_load_ok_r <= q_item.load_ok;
      s1_addr_r    <= s1_addr_nxt;
      s1_word_r    <= q_item.word;
      s1_p0_r      <= q_item.pix0;
      s1_p1_r      <= q_item.pix1;
      s1_p2_r      <= q_item.pix2;
      s1_last_r    <= q_item.last;
      s1_hit_r     <= q_item.hit;
    end
  end

  // Single port: a load writes, a pixel reads, one request per cycle while the stages behind it are not stalled.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      if (s1_load_r) begin
        if (s1_load_ok_r) mem[s1_addr_r] <= s1_word_r;
      end else begin
        rd_r <= mem[s1_addr_r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && !s1_load_r) begin
      s2_p0_r   <= s1_p0_r;
      s2_p1_r   <= s1_p1_r;
      s2_p2_r   <= s1_p2_r;
      s2_last_r <= s1_last_r;
      s2_hit_r  <= s1_hit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_v_r && s3_rdy) begin
      s3_p0_r   <= s2_p0_r;
      s3_p1_r   <= s2_p1_r;
      s3_p2_r   <= s2_p2_r;
      s3_c0_r   <= rd_r[7:0];
      s3_c1_r   <= rd_r[15:8];
      s3_c2_r   <= rd_r[23:16];
      s3_m0_r   <= m0_nxt;
      s3_m1_r   <= m1_nxt;
      s3_m2_r   <= m2_nxt;
      s3_full_r <= (rd_r[31:24] == ALPHA_FULL);
      s3_zero_r <= (rd_r[31:24] == ALPHA_NONE);
      s3_hit_r  <= s2_hit_r;
      s3_last_r <= s2_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_v_r && out_rdy) begin
      out_c0_r   <= mix(s3_hit_r, s3_full_r, s3_zero_r, s3_p0_r, s3_c0_r, s3_m0_r);
      out_c1_r   <= mix(s3_hit_r, s3_full_r, s3_zero_r, s3_p1_r, s3_c1_r, s3_m1_r);
      out_c2_r   <= mix(s3_hit_r, s3_full_r, s3_zero_r, s3_p2_r, s3_c2_r, s3_m2_r);
      out_last_r <= s3_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_c0    = out_c0_r;
  assign out_c1    = out_c1_r;
  assign out_c2    = out_c2_r;
  assign out_last  = out_last_r;

  `CAO_ASSERT(a_rd_hold, (s2_v_r && !s3_rdy) |=> (s2_v_r && $stable(rd_r)), "read data lost while stalled")
  `CAO_ASSERT(a_load_no_result, (s1_v_r && s1_load_r && s2_rdy) |=> !s2_v_r, "load produced a result")
  `CAO_ASSERT(a_miss_pass, (s3_v_r && !s3_hit_r && out_rdy) |=> (out_c0_r == $past(s3_p0_r)), "uncovered pixel altered")

endmodule

`default_nettype wire

/* rtl/core/cursor_alpha_overlay_core.sv */
// Cursor alpha overlay core: one pixel or cursor-load request per clock, sustained while
// out_stall is low. A request accepted on in_valid without in_stall enters a four-entry
// queue; its result, if it is a pixel, shows on out_valid after the queue and the
// address, memory read, multiply and output register stages. Every request, load or
// pixel, uses the single cursor memory port once, and that port sets the rate of one
// request per clock. in_stall rises only when the queue is full, i.e. only after
// out_stall has held the back end and the queue has filled. Loads produce no result. The
// cursor memory is not cleared: entries read before they are loaded return undefined color.
// Depends on cao_pkg, cao_front, cao_queue and cao_back.
`timescale 1ns / 1ps
`default_nettype none

module cursor_alpha_overlay_core import cao_pkg::*; #(
  parameter int MAX_CURSOR_SIDE = MAX_CURSOR_SIDE_DEF,
  parameter int MAX_FRAME_WIDTH = MAX_FRAME_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_opcode,
  input  wire logic [11:0]           in_cursor_index,
  input  wire logic [31:0]           in_cursor_word,
  input  wire logic [7:0]            in_pixel_c0,
  input  wire logic [7:0]            in_pixel_c1,
  input  wire logic [7:0]            in_pixel_c2,
  input  wire logic                  in_last_of_frame,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [7:0]                 out_c0,
  output logic [7:0]                 out_c1,
  output logic [7:0]                 out_c2,
  output logic                       out_last
);

  localparam int SIDE_W = $clog2(MAX_CURSOR_SIDE);
  localparam int CW_W   = $clog2(MAX_CURSOR_SIDE + 1);

  cfg_t              cfg_r;
  logic [CW_W-1:0]   cw_eff, ch_eff;

  logic              q_full, push, head_valid, pop;
  item_t             push_item, head_item;
  logic [SIDE_W-1:0] push_dx, push_dy, head_dx, head_dy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cursor_left    <= CURSOR_LEFT_RST;
      cfg_r.cursor_top     <= CURSOR_TOP_RST;
      cfg_r.cursor_width   <= CURSOR_WIDTH_RST;
      cfg_r.cursor_height  <= CURSOR_HEIGHT_RST;
      cfg_r.frame_width    <= FRAME_WIDTH_RST;
      cfg_r.overlay_enable <= OVERLAY_ENABLE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CURSOR_LEFT:    cfg_r.cursor_left    <= cfg_wdata[13:0];
        REG_CURSOR_TOP:     cfg_r.cursor_top     <= cfg_wdata[13:0];
        REG_CURSOR_WIDTH:   cfg_r.cursor_width   <= cfg_wdata[6:0];
        REG_CURSOR_HEIGHT:  cfg_r.cursor_height  <= cfg_wdata[6:0];
        REG_FRAME_WIDTH:    cfg_r.frame_width    <= cfg_wdata[12:0];
        REG_OVERLAY_ENABLE: cfg_r.overlay_enable <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Saturate the cursor size at the memory's side length.
  assign cw_eff = (32'(cfg_r.cursor_width) > 32'(MAX_CURSOR_SIDE)) ?
                  CW_W'(MAX_CURSOR_SIDE) : CW_W'(cfg_r.cursor_width);
  assign ch_eff = (32'(cfg_r.cursor_height) > 32'(MAX_CURSOR_SIDE)) ?
                  CW_W'(MAX_CURSOR_SIDE) : CW_W'(cfg_r.cursor_height);

  cao_front #(
    .MAX_CURSOR_SIDE(MAX_CURSOR_SIDE),
    .MAX_FRAME_WIDTH(MAX_FRAME_WIDTH)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .cw_eff           (cw_eff),
    .ch_eff           (ch_eff),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_cursor_index  (in_cursor_index),
    .in_cursor_word   (in_cursor_word),
    .in_pixel_c0      (in_pixel_c0),
    .in_pixel_c1      (in_pixel_c1),
    .in_pixel_c2      (in_pixel_c2),
    .in_last_of_frame (in_last_of_frame),
    .q_full           (q_full),
    .push             (push),
    .push_item        (push_item),
    .push_dx          (push_dx),
    .push_dy          (push_dy)
  );

  cao_queue #(
    .OFS_W(SIDE_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .push_dx    (push_dx),
    .push_dy    (push_dy),
    .full       (q_full),
    .head_valid (head_valid),
    .head_item  (head_item),
    .head_dx    (head_dx),
    .head_dy    (head_dy),
    .pop        (pop)
  );

  cao_back #(
    .MAX_CURSOR_SIDE(MAX_CURSOR_SIDE)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cw_eff    (cw_eff),
    .q_valid   (head_valid),
    .q_item    (head_item),
    .q_dx      (head_dx),
    .q_dy      (head_dy),
    .q_pop     (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_c0    (out_c0),
    .out_c1    (out_c1),
    .out_c2    (out_c2),
    .out_last  (out_last)
  );

endmodule

`default_nettype wire
